### rtl/cnc_move_sequencer_backlash_assert.svh
// assertion macros for the cnc move sequencer
// used by the top level only, no other dependencies
`ifndef CNC_MOVE_SEQUENCER_BACKLASH_ASSERT_SVH
`define CNC_MOVE_SEQUENCER_BACKLASH_ASSERT_SVH

// same-cycle implication, off while reset is high
`define CMS_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define CMS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cms_pkg.sv
// shared types and constants for the cnc move sequencer
// no dependencies
`default_nettype none

package cms_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FEED_BITS_DEF  = 16;
  localparam int SLACK_BITS     = 16;
  localparam int OFF_BITS       = SLACK_BITS + 1;
  localparam int CFG_IDX_BITS   = 3;
  localparam int REQ_DEPTH      = 2;
  localparam int MOVE_DEPTH     = 2;

  localparam int FEED_CUT_RST  = 30;
  localparam int FEED_SKIP_RST = 500;

  // mode register bits
  localparam int MODE_TRAVEL_LINEAR = 0;
  localparam int MODE_NEGATE        = 1;

  localparam logic MOTION_RAPID  = 1'b0;
  localparam logic MOTION_LINEAR = 1'b1;

  typedef enum logic [1:0] {
    ACT_CUT    = 2'd0,
    ACT_TRAVEL = 2'd1,
    ACT_LIFT   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_Z_CUT        = 3'd0,
    CFG_Z_CLEAR      = 3'd1,
    CFG_Z_SKIP       = 3'd2,
    CFG_HALF_SLACK_X = 3'd3,
    CFG_HALF_SLACK_Y = 3'd4,
    CFG_FEED_CUT     = 3'd5,
    CFG_FEED_SKIP    = 3'd6,
    CFG_MODE_FLAGS   = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    PH_MAIN = 1'b0,
    PH_Z2   = 1'b1
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_Z1    = 3'd1,
    OP_Z2    = 3'd2,
    OP_CORR  = 3'd3,
    OP_FINAL = 3'd4
  } op_t;

endpackage

`default_nettype wire

### rtl/cms_fifo.sv
// small register queue with registered storage, push/full and pop/empty
// no dependencies
`default_nettype none

module cms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cms_front.sv
// front end: takes requests, drops unused action codes, queues the rest
// depends on cms_pkg and cms_fifo
`default_nettype none

module cms_front import cms_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   action,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  input  wire logic signed [COORD_BITS-1:0] z_height,
  output logic                              req_valid,
  input  wire logic                         req_pop,
  output action_t                           req_kind,
  output logic signed [COORD_BITS-1:0]      req_x,
  output logic signed [COORD_BITS-1:0]      req_y,
  output logic signed [COORD_BITS-1:0]      req_z
);

  localparam int REQ_W = 2 + 3 * COORD_BITS;

  logic             known;
  logic             q_push;
  logic             q_empty;
  logic [REQ_W-1:0] q_wr, q_rd;

  // unused action code: the item is taken and produces nothing
  always_comb begin
    unique case (action)
      ACT_CUT, ACT_TRAVEL, ACT_LIFT: known = 1'b1;
      default:                       known = 1'b0;
    endcase
  end

  assign q_push = push && known;
  assign q_wr   = {action, x_coord, y_coord, z_height};

  cms_fifo #(
    .WIDTH (REQ_W),
    .DEPTH (REQ_DEPTH)
  ) u_req_q (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (full),
    .pop     (req_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  assign req_valid = !q_empty;
  assign req_kind  = action_t'(q_rd[REQ_W-1 -: 2]);
  assign req_x     = q_rd[3*COORD_BITS-1 -: COORD_BITS];
  assign req_y     = q_rd[2*COORD_BITS-1 -: COORD_BITS];
  assign req_z     = q_rd[COORD_BITS-1:0];

endmodule

`default_nettype wire

### rtl/cms_back.sv
// back end: expands one request into tool moves with backlash offsets
// depends on cms_pkg and cms_fifo
`default_nettype none

module cms_back import cms_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FEED_BITS  = FEED_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_pop,
  input  wire action_t                      req_kind,
  input  wire logic signed [COORD_BITS-1:0] req_x,
  input  wire logic signed [COORD_BITS-1:0] req_y,
  input  wire logic signed [COORD_BITS-1:0] req_z,
  input  wire logic signed [COORD_BITS-1:0] z_cut,
  input  wire logic signed [COORD_BITS-1:0] z_clear,
  input  wire logic signed [COORD_BITS-1:0] z_skip,
  input  wire logic [SLACK_BITS-1:0]        half_slack_x,
  input  wire logic [SLACK_BITS-1:0]        half_slack_y,
  input  wire logic [FEED_BITS-1:0]         feed_cut,
  input  wire logic [FEED_BITS-1:0]         feed_skip,
  input  wire logic [1:0]                   mode_flags,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              motion_code,
  output logic                              has_x,
  output logic signed [COORD_BITS:0]        x_pos,
  output logic                              has_y,
  output logic signed [COORD_BITS:0]        y_pos,
  output logic                              has_z,
  output logic signed [COORD_BITS-1:0]      z_pos,
  output logic                              has_feed,
  output logic [FEED_BITS-1:0]              feed_rate,
  output logic                              last
);

  localparam int SUM_W  = (COORD_BITS + 1 > OFF_BITS) ? COORD_BITS + 1 : OFF_BITS;
  localparam int MOVE_W = 6 + 2 * (COORD_BITS + 1) + COORD_BITS + FEED_BITS;

  // current request
  logic                         cur_valid;
  action_t                      cur_kind;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, cur_z;
  phase_t                       ph, ph_next;

  // machine state
  logic signed [COORD_BITS-1:0] last_x, last_y;
  logic signed [OFF_BITS-1:0]   applied_x, applied_y, pending_x, pending_y;
  logic                         tool_up;
  logic [FEED_BITS-1:0]         last_feed;

  logic                         is_cut, is_travel, is_lift;
  logic                         same, toggle, diag, tc;
  logic signed [OFF_BITS-1:0]   hx, hy, px_new, py_new;
  op_t                          op;
  logic                         fire, step_done;
  logic                         out_full;
  logic [MOVE_W-1:0]            out_wr, out_rd;

  // move being built
  logic                         mv_code, mv_has_x, mv_has_y, mv_has_z, mv_last;
  logic signed [COORD_BITS-1:0] tx, ty, mv_z;
  logic [FEED_BITS-1:0]         mv_feed;
  logic signed [SUM_W-1:0]      sum_x, sum_y, val_x, val_y;
  logic signed [COORD_BITS:0]   mv_x, mv_y;

  assign is_cut    = (cur_kind == ACT_CUT);
  assign is_travel = (cur_kind == ACT_TRAVEL);
  assign is_lift   = (cur_kind == ACT_LIFT);
  assign tc        = mode_flags[MODE_TRAVEL_LINEAR];
  assign same      = (cur_x == last_x) && (cur_y == last_y);

  assign hx = {1'b0, half_slack_x};
  assign hy = {1'b0, half_slack_y};

  // offset follows direction; unchanged when the axis does not move
  always_comb begin
    if (cur_x < last_x) begin
      px_new = -hx;
    end else if (cur_x > last_x) begin
      px_new = hx;
    end else begin
      px_new = pending_x;
    end
    if (cur_y < last_y) begin
      py_new = -hy;
    end else if (cur_y > last_y) begin
      py_new = hy;
    end else begin
      py_new = pending_y;
    end
  end

  // tool has to change height before anything else
  always_comb begin
    priority if (is_cut) begin
      toggle = tool_up && !same;
    end else if (is_travel) begin
      toggle = !tool_up && !same;
    end else begin
      toggle = !tool_up;
    end
  end

  assign diag = is_cut && !same && (cur_x != last_x) && (cur_y != last_y) &&
                ((applied_x != px_new) || (applied_y != py_new));

  // which move this cycle offers
  always_comb begin
    priority if (!cur_valid) begin
      op = OP_NONE;
    end else if (ph == PH_Z2) begin
      op = OP_Z2;
    end else if (toggle) begin
      op = OP_Z1;
    end else if (diag) begin
      op = OP_CORR;
    end else if ((is_cut || is_travel) && !same) begin
      op = OP_FINAL;
    end else begin
      op = OP_NONE;
    end
  end

  assign fire      = (op != OP_NONE) && !out_full;
  assign step_done = cur_valid &&
                     ((op == OP_NONE) ||
                      (fire && ((op == OP_FINAL) || ((op == OP_Z2) && is_lift))));
  assign req_pop   = req_valid && (!cur_valid || step_done);

  always_comb begin
    ph_next = ph;
    unique case (ph)
      PH_MAIN: if (fire && (op == OP_Z1)) ph_next = PH_Z2;
      PH_Z2:   if (fire) ph_next = PH_MAIN;
    endcase
  end

  always_comb begin
    mv_code  = MOTION_LINEAR;
    mv_has_x = 1'b0;
    mv_has_y = 1'b0;
    mv_has_z = 1'b0;
    mv_z     = '0;
    mv_feed  = feed_skip;
    mv_last  = 1'b0;
    tx       = last_x;
    ty       = last_y;
    unique case (op)
      OP_Z1: begin
        mv_code  = is_cut ? tc : MOTION_LINEAR;
        mv_has_z = 1'b1;
        mv_z     = z_clear;
      end
      OP_Z2: begin
        mv_has_z = 1'b1;
        mv_last  = is_lift;
        if (is_cut) begin
          mv_code = MOTION_LINEAR;
          mv_z    = z_cut;
          mv_feed = feed_cut;
        end else begin
          mv_code = tc;
          mv_z    = is_lift ? cur_z : z_skip;
        end
      end
      OP_CORR: begin
        mv_has_x = (applied_x != px_new);
        mv_has_y = (applied_y != py_new);
        mv_feed  = feed_cut;
      end
      OP_FINAL: begin
        tx       = cur_x;
        ty       = cur_y;
        mv_code  = is_cut ? MOTION_LINEAR : tc;
        mv_has_x = (cur_x != last_x) || (applied_x != px_new);
        mv_has_y = (cur_y != last_y) || (applied_y != py_new);
        mv_feed  = is_cut ? feed_cut : feed_skip;
        mv_last  = 1'b1;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign sum_x = SUM_W'(tx) + SUM_W'(px_new);
  assign sum_y = SUM_W'(ty) + SUM_W'(py_new);
  assign val_x = mode_flags[MODE_NEGATE] ? -sum_x : sum_x;
  assign val_y = mode_flags[MODE_NEGATE] ? -sum_y : sum_y;
  assign mv_x  = mv_has_x ? val_x[COORD_BITS:0] : '0;
  assign mv_y  = mv_has_y ? val_y[COORD_BITS:0] : '0;

  assign out_wr = {mv_code, mv_has_x, mv_x, mv_has_y, mv_y, mv_has_z, mv_z,
                   (mv_feed != last_feed), mv_feed, mv_last};

  always_ff @(posedge clk) begin
    if (req_pop) begin
      cur_kind <= req_kind;
      cur_x    <= req_x;
      cur_y    <= req_y;
      cur_z    <= req_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      ph        <= PH_MAIN;
      last_x    <= '0;
      last_y    <= '0;
      applied_x <= '0;
      applied_y <= '0;
      pending_x <= '0;
      pending_y <= '0;
      tool_up   <= 1'b0;
      last_feed <= '0;
    end else begin
      if (req_pop) begin
        cur_valid <= 1'b1;
      end else if (step_done) begin
        cur_valid <= 1'b0;
      end
      ph <= ph_next;
      if (fire) begin
        last_feed <= mv_feed;
      end
      if (fire && (op == OP_Z2)) begin
        tool_up <= !is_cut;
      end
      if (fire && ((op == OP_CORR) || (op == OP_FINAL))) begin
        last_x    <= tx;
        last_y    <= ty;
        applied_x <= px_new;
        applied_y <= py_new;
        pending_x <= px_new;
        pending_y <= py_new;
      end
    end
  end

  cms_fifo #(
    .WIDTH (MOVE_W),
    .DEPTH (MOVE_DEPTH)
  ) u_move_q (
    .clk     (clk),
    .rst     (rst),
    .push    (fire),
    .wr_data (out_wr),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_rd),
    .empty   (empty)
  );

  assign {motion_code, has_x, x_pos, has_y, y_pos, has_z, z_pos,
          has_feed, feed_rate, last} = out_rd;

endmodule

`default_nettype wire

### rtl/cnc_move_sequencer_backlash.sv
// cnc move sequencer with backlash compensation, top level: config registers,
// front request queue and back move generator (cms_pkg, cms_front, cms_back)
// path: request queue, then the back end's current-request registers, then the move queue
// throughput: one move per cycle out of the back end's step sequencer while the move
// queue has room, up to four moves per request, the next request loaded with the last move
// reset (rst, synchronous): queues emptied, position/offsets/tool/feed cleared
`default_nettype none

`include "cnc_move_sequencer_backlash_assert.svh"

module cnc_move_sequencer_backlash import cms_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FEED_BITS  = FEED_BITS_DEF,
  // config data carries the widest register
  parameter int CFG_DATA_W = (COORD_BITS > FEED_BITS) ?
                             ((COORD_BITS > SLACK_BITS) ? COORD_BITS : SLACK_BITS) :
                             ((FEED_BITS > SLACK_BITS) ? FEED_BITS : SLACK_BITS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // request side
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   action,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  input  wire logic signed [COORD_BITS-1:0] z_height,
  // move side
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              motion_code,
  output logic                              has_x,
  output logic signed [COORD_BITS:0]        x_pos,
  output logic                              has_y,
  output logic signed [COORD_BITS:0]        y_pos,
  output logic                              has_z,
  output logic signed [COORD_BITS-1:0]      z_pos,
  output logic                              has_feed,
  output logic [FEED_BITS-1:0]              feed_rate,
  output logic                              last,
  // configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  // configuration registers
  logic signed [COORD_BITS-1:0] z_cut, z_clear, z_skip;
  logic [SLACK_BITS-1:0]        half_slack_x, half_slack_y;
  logic [FEED_BITS-1:0]         feed_cut, feed_skip;
  logic [1:0]                   mode_flags;

  // front to back request handshake
  logic                         req_valid, req_pop;
  action_t                      req_kind;
  logic signed [COORD_BITS-1:0] req_x, req_y, req_z;

  // writes are to be issued only while idle; the block does not enforce it and is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_cut        <= '0;
      z_clear      <= '0;
      z_skip       <= '0;
      half_slack_x <= '0;
      half_slack_y <= '0;
      feed_cut     <= FEED_BITS'(FEED_CUT_RST);
      feed_skip    <= FEED_BITS'(FEED_SKIP_RST);
      mode_flags   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_Z_CUT:        z_cut        <= cfg_data[COORD_BITS-1:0];
        CFG_Z_CLEAR:      z_clear      <= cfg_data[COORD_BITS-1:0];
        CFG_Z_SKIP:       z_skip       <= cfg_data[COORD_BITS-1:0];
        CFG_HALF_SLACK_X: half_slack_x <= cfg_data[SLACK_BITS-1:0];
        CFG_HALF_SLACK_Y: half_slack_y <= cfg_data[SLACK_BITS-1:0];
        CFG_FEED_CUT:     feed_cut     <= cfg_data[FEED_BITS-1:0];
        CFG_FEED_SKIP:    feed_skip    <= cfg_data[FEED_BITS-1:0];
        CFG_MODE_FLAGS:   mode_flags   <= cfg_data[1:0];
      endcase
    end
  end

  // front: filters unused actions and buffers requests
  cms_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .z_height  (z_height),
    .req_valid (req_valid),
    .req_pop   (req_pop),
    .req_kind  (req_kind),
    .req_x     (req_x),
    .req_y     (req_y),
    .req_z     (req_z)
  );

  // back: tool raise/lower, backlash correction and the move itself,
  // one move per cycle, while it has room, into a small output queue
  cms_back #(
    .COORD_BITS (COORD_BITS),
    .FEED_BITS  (FEED_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_pop      (req_pop),
    .req_kind     (req_kind),
    .req_x        (req_x),
    .req_y        (req_y),
    .req_z        (req_z),
    .z_cut        (z_cut),
    .z_clear      (z_clear),
    .z_skip       (z_skip),
    .half_slack_x (half_slack_x),
    .half_slack_y (half_slack_y),
    .feed_cut     (feed_cut),
    .feed_skip    (feed_skip),
    .mode_flags   (mode_flags),
    .empty        (empty),
    .pop          (pop),
    .motion_code  (motion_code),
    .has_x        (has_x),
    .x_pos        (x_pos),
    .has_y        (has_y),
    .y_pos        (y_pos),
    .has_z        (has_z),
    .z_pos        (z_pos),
    .has_feed     (has_feed),
    .feed_rate    (feed_rate),
    .last         (last)
  );

  // absent words read as zero
  `CMS_ASSERT_HOLDS(a_absent_zero, clk, rst, !empty, (has_x || x_pos == '0) && (has_y || y_pos == '0) && (has_z || z_pos == '0), "absent word not zero")
  // a height move never carries an xy word
  `CMS_ASSERT_HOLDS(a_z_alone, clk, rst, !empty && has_z, !has_x && !has_y, "z move with xy word")
  // the move queue comes out of reset empty and the request queue not full
  `CMS_ASSERT_NEXT(a_reset_empty, clk, rst, empty && !full, "queues not empty after reset")

endmodule

`default_nettype wire

### tb/sv/cnc_move_checker.sv
// move checker for the cnc move sequencer: follows the config, request and move
// channels, predicts every move and compares it field by field
// depends on cms_pkg only
`default_nettype none

module cnc_move_checker import cms_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  logic [1:0]                       action,
  input  logic signed [COORD_BITS_DEF-1:0] x_coord,
  input  logic signed [COORD_BITS_DEF-1:0] y_coord,
  input  logic signed [COORD_BITS_DEF-1:0] z_height,
  input  logic                             empty,
  input  logic                             pop,
  input  logic                             motion_code,
  input  logic                             has_x,
  input  logic signed [COORD_BITS_DEF:0]   x_pos,
  input  logic                             has_y,
  input  logic signed [COORD_BITS_DEF:0]   y_pos,
  input  logic                             has_z,
  input  logic signed [COORD_BITS_DEF-1:0] z_pos,
  input  logic                             has_feed,
  input  logic [FEED_BITS_DEF-1:0]         feed_rate,
  input  logic                             last,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]          cfg_index,
  input  logic [COORD_BITS_DEF-1:0]        cfg_data,
  output int                               mismatches,
  output int                               moves_due,
  output int                               moves_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_BITS_DEF;
  localparam int FW = FEED_BITS_DEF;

  typedef logic signed [CW-1:0]       coord_t;
  typedef logic signed [CW:0]         wide_t;
  typedef logic signed [OFF_BITS-1:0] off_t;

  typedef struct packed {
    logic          motion_code;
    logic          has_x;
    logic [CW:0]   x_pos;
    logic          has_y;
    logic [CW:0]   y_pos;
    logic          has_z;
    logic [CW-1:0] z_pos;
    logic          has_feed;
    logic [FW-1:0] feed_rate;
    logic          last;
  } move_t;

  // register copies
  coord_t                z_cut_r, z_clear_r, z_skip_r;
  logic [SLACK_BITS-1:0] slack_x_r, slack_y_r;
  logic [FW-1:0]         feed_cut_r, feed_skip_r;
  logic [1:0]            mode_r;

  // machine state
  coord_t        pos_x, pos_y;
  off_t          app_x, app_y, pend_x, pend_y;
  logic          tool_up;
  logic [FW-1:0] feed_prev;

  move_t pending_moves[$];
  move_t batch[$];
  int    errs;
  int    checked;

  task automatic add_move(input logic code, input logic hx, input wide_t xv,
                          input logic hy, input wide_t yv, input logic hz,
                          input coord_t zv, input logic [FW-1:0] feed);
    move_t m;
    m.motion_code = code;
    m.has_x       = hx;
    m.x_pos       = hx ? xv : '0;
    m.has_y       = hy;
    m.y_pos       = hy ? yv : '0;
    m.has_z       = hz;
    m.z_pos       = hz ? zv : '0;
    m.has_feed    = (feed != feed_prev);
    m.feed_rate   = feed;
    m.last        = 1'b0;
    feed_prev     = feed;
    batch.push_back(m);
  endtask

  // an axis word goes out when the position or the offset has moved on
  task automatic axis_word(input coord_t tgt, inout coord_t pos, inout off_t app,
                           input off_t pend, output logic has, output wide_t val);
    if (tgt != pos || app != pend) begin
      pos = tgt;
      app = pend;
      val = tgt + app;
      if (mode_r[MODE_NEGATE]) val = -val;
      has = 1'b1;
    end else begin
      has = 1'b0;
      val = '0;
    end
  endtask

  task automatic raise_tool(input coord_t z);
    if (!tool_up) begin
      add_move(MOTION_LINEAR, 1'b0, '0, 1'b0, '0, 1'b1, z_clear_r, feed_skip_r);
      add_move(mode_r[MODE_TRAVEL_LINEAR], 1'b0, '0, 1'b0, '0, 1'b1, z, feed_skip_r);
      tool_up = 1'b1;
    end
  endtask

  task automatic lower_tool();
    if (tool_up) begin
      add_move(mode_r[MODE_TRAVEL_LINEAR], 1'b0, '0, 1'b0, '0, 1'b1, z_clear_r,
               feed_skip_r);
      add_move(MOTION_LINEAR, 1'b0, '0, 1'b0, '0, 1'b1, z_cut_r, feed_cut_r);
      tool_up = 1'b0;
    end
  endtask

  // offset follows the direction of motion, kept when an axis stands still
  task automatic aim_offsets(input coord_t x, input coord_t y);
    off_t sx, sy;
    sx = {1'b0, slack_x_r};
    sy = {1'b0, slack_y_r};
    if (x < pos_x) pend_x = -sx;
    else if (x > pos_x) pend_x = sx;
    if (y < pos_y) pend_y = -sy;
    else if (y > pos_y) pend_y = sy;
  endtask

  task automatic go_to(input logic code, input coord_t x, input coord_t y,
                       input logic [FW-1:0] feed);
    logic  hx, hy;
    wide_t xv, yv;
    axis_word(x, pos_x, app_x, pend_x, hx, xv);
    axis_word(y, pos_y, app_y, pend_y, hy, yv);
    add_move(code, hx, xv, hy, yv, 1'b0, '0, feed);
  endtask

  task automatic plan_request(input logic [1:0] act, input coord_t x, input coord_t y,
                              input coord_t z);
    batch.delete();
    case (act)
      ACT_CUT: begin
        if (x != pos_x || y != pos_y) begin
          aim_offsets(x, y);
          // diagonal with a direction flip: take up the slack on the spot first
          if (x != pos_x && y != pos_y && (app_x != pend_x || app_y != pend_y)) begin
            lower_tool();
            go_to(MOTION_LINEAR, pos_x, pos_y, feed_cut_r);
          end
          lower_tool();
          go_to(MOTION_LINEAR, x, y, feed_cut_r);
        end
      end
      ACT_TRAVEL: begin
        if (x != pos_x || y != pos_y) begin
          raise_tool(z_skip_r);
          aim_offsets(x, y);
          go_to(mode_r[MODE_TRAVEL_LINEAR], x, y, feed_skip_r);
        end
      end
      ACT_LIFT: raise_tool(z);
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_moves.push_back(batch[i]);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    move_t m;
    if (rst) begin
      z_cut_r     = '0;
      z_clear_r   = '0;
      z_skip_r    = '0;
      slack_x_r   = '0;
      slack_y_r   = '0;
      feed_cut_r  = FW'(FEED_CUT_RST);
      feed_skip_r = FW'(FEED_SKIP_RST);
      mode_r      = '0;
      pos_x       = '0;
      pos_y       = '0;
      app_x       = '0;
      app_y       = '0;
      pend_x      = '0;
      pend_y      = '0;
      tool_up     = 1'b0;
      feed_prev   = '0;
      pending_moves.delete();
      errs        = 0;
      checked     = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_Z_CUT:        z_cut_r     = cfg_data[CW-1:0];
          CFG_Z_CLEAR:      z_clear_r   = cfg_data[CW-1:0];
          CFG_Z_SKIP:       z_skip_r    = cfg_data[CW-1:0];
          CFG_HALF_SLACK_X: slack_x_r   = cfg_data[SLACK_BITS-1:0];
          CFG_HALF_SLACK_Y: slack_y_r   = cfg_data[SLACK_BITS-1:0];
          CFG_FEED_CUT:     feed_cut_r  = cfg_data[FW-1:0];
          CFG_FEED_SKIP:    feed_skip_r = cfg_data[FW-1:0];
          CFG_MODE_FLAGS:   mode_r      = cfg_data[1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pending_moves.size() == 0) begin
          $error("move popped with none expected");
          errs++;
        end else begin
          m = pending_moves.pop_front();
          check_field("motion_code", m.motion_code, motion_code);
          check_field("has_x", m.has_x, has_x);
          check_field("x_pos", $signed(m.x_pos), x_pos);
          check_field("has_y", m.has_y, has_y);
          check_field("y_pos", $signed(m.y_pos), y_pos);
          check_field("has_z", m.has_z, has_z);
          check_field("z_pos", $signed(m.z_pos), z_pos);
          check_field("has_feed", m.has_feed, has_feed);
          check_field("feed_rate", m.feed_rate, feed_rate);
          check_field("last", m.last, last);
          checked++;
        end
      end
      if (push && !full) plan_request(action, x_coord, y_coord, z_height);
    end
    mismatches    <= errs;
    moves_due     <= pending_moves.size();
    moves_checked <= checked;
  end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// top of the cnc move sequencer testbench: clock, reset, config setups and
// request stimulus; the move checker does all prediction and comparison
// depends on cms_pkg, cnc_move_checker and the block itself
`default_nettype none

module testbench import cms_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_BITS_DEF;
  localparam int FW = FEED_BITS_DEF;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t     COORD_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t     COORD_MAX  = {1'b0, {(CW-1){1'b1}}};
  // the one action code the block has no use for
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // one complete register setup
  typedef struct packed {
    logic [CW-1:0]         z_cut;
    logic [CW-1:0]         z_clear;
    logic [CW-1:0]         z_skip;
    logic [SLACK_BITS-1:0] slack_x;
    logic [SLACK_BITS-1:0] slack_y;
    logic [FW-1:0]         feed_cut;
    logic [FW-1:0]         feed_skip;
    logic [1:0]            mode;
  } machine_cfg_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    push      = 1'b0;
  logic                    full;
  logic [1:0]              action    = ACT_CUT;
  coord_t                  x_coord   = '0;
  coord_t                  y_coord   = '0;
  coord_t                  z_height  = '0;
  logic                    empty;
  logic                    pop       = 1'b0;
  logic                    motion_code;
  logic                    has_x;
  logic signed [CW:0]      x_pos;
  logic                    has_y;
  logic signed [CW:0]      y_pos;
  logic                    has_z;
  logic signed [CW-1:0]    z_pos;
  logic                    has_feed;
  logic [FW-1:0]           feed_rate;
  logic                    last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_Z_CUT;
  logic [CW-1:0]           cfg_data  = '0;

  int mismatches;
  int moves_due;
  int moves_checked;

  int     idle_pct = 30;  // chance in a hundred that either side idles
  int     n_items  = 0;
  coord_t cur_x    = '0;  // where the random walk last aimed
  coord_t cur_y    = '0;

  cnc_move_sequencer_backlash u_dut (.*);

  cnc_move_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // move side: random back-pressure from the consumer
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(0, 99) >= idle_pct);
  end

  // write all eight registers back to back, valid held high between them
  task automatic load_setup(input machine_cfg_t c);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      case (cfg_reg_t'(i))
        CFG_Z_CUT:        cfg_data <= c.z_cut;
        CFG_Z_CLEAR:      cfg_data <= c.z_clear;
        CFG_Z_SKIP:       cfg_data <= c.z_skip;
        CFG_HALF_SLACK_X: cfg_data <= CW'(c.slack_x);
        CFG_HALF_SLACK_Y: cfg_data <= CW'(c.slack_y);
        CFG_FEED_CUT:     cfg_data <= CW'(c.feed_cut);
        CFG_FEED_SKIP:    cfg_data <= CW'(c.feed_skip);
        CFG_MODE_FLAGS:   cfg_data <= CW'(c.mode);
        default: ;
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // push one request, sometimes after a short random gap; push stays high afterwards
  task automatic send_item(input logic [1:0] act, input coord_t x, input coord_t y,
                           input coord_t z);
    if ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    push     <= 1'b1;
    action   <= act;
    x_coord  <= x;
    y_coord  <= y;
    z_height <= z;
    do @(posedge clk); while (full);
    n_items++;
  endtask

  // hold off until every predicted move is out, then let the request queue
  // run dry of requests that cause no moves
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (moves_due != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // mostly short steps around the last target so directions keep flipping,
  // with repeats of the same point and the odd far jump or extreme
  function automatic coord_t pick_coord(input coord_t near);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return near;
    if (r < 70) return coord_t'(int'(near) + int'($urandom_range(0, 40)) - 20);
    if (r < 86) return coord_t'($urandom);
    if (r < 93) return COORD_MIN;
    return COORD_MAX;
  endfunction

  function automatic machine_cfg_t rand_setup(input logic [1:0] mode);
    machine_cfg_t c;
    c.z_cut     = CW'($urandom);
    c.z_clear   = CW'($urandom);
    c.z_skip    = CW'($urandom);
    c.slack_x   = SLACK_BITS'($urandom_range(0, 300));
    c.slack_y   = SLACK_BITS'($urandom);
    c.feed_cut  = FW'($urandom);
    c.feed_skip = FW'($urandom);
    c.mode      = mode;
    return c;
  endfunction

  // random tool path: cuts and travels mixed with lifts, a few ignored codes
  // and an occasional pause until the block is empty
  task automatic random_run(input int n);
    int         done;
    int         r;
    logic [1:0] act;
    coord_t     x, y, z;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) act = ACT_CUT;
      else if (r < 75) act = ACT_TRAVEL;
      else if (r < 95) act = ACT_LIFT;
      else act = ACT_UNUSED;
      x = pick_coord(cur_x);
      y = pick_coord(cur_y);
      z = coord_t'($urandom);
      if ($urandom_range(0, 99) < 3) wait_drained();
      send_item(act, x, y, z);
      if (act != ACT_UNUSED) done++;
      if (act == ACT_CUT || act == ACT_TRAVEL) begin
        cur_x = x;
        cur_y = y;
      end
    end
  endtask

  initial begin : stimulus
    machine_cfg_t c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // plain setup with small slack, rapid travel
    c = '{z_cut: CW'(-120), z_clear: CW'(40), z_skip: CW'(800), slack_x: 3, slack_y: 5,
          feed_cut: 120, feed_skip: 900, mode: 2'b00};
    load_setup(c);

    send_item(ACT_CUT, 0, 0, 0);                  // same point, tool down: nothing
    send_item(ACT_LIFT, 0, 0, 2000);              // raise through clearance
    send_item(ACT_LIFT, 0, 0, 7);                 // lift while already up
    send_item(ACT_TRAVEL, 10, 10, 0);             // travel with the tool up
    send_item(ACT_TRAVEL, 10, 10, 0);             // travel to the same point
    send_item(ACT_CUT, 25, 10, 0);                // lower, then x-only cut
    send_item(ACT_CUT, 40, -6, 0);                // diagonal, y reverses
    send_item(ACT_CUT, 30, -20, 0);               // diagonal, x reverses
    send_item(ACT_CUT, 30, -20, 0);               // cut to the same point
    send_item(ACT_UNUSED, 1234, -1, COORD_MAX);   // ignored code
    send_item(ACT_TRAVEL, COORD_MIN, COORD_MAX, 0);
    send_item(ACT_CUT, COORD_MAX, COORD_MIN, 0);
    send_item(ACT_LIFT, 0, 0, COORD_MIN);
    send_item(ACT_TRAVEL, COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(ACT_CUT, 0, 0, 0);
    send_item(ACT_CUT, -1, -1, 0);
    wait_drained();

    // extremes: full slack, negated axes, linear travel, zero skip feed
    c = '{z_cut: COORD_MIN, z_clear: COORD_MAX, z_skip: '0, slack_x: '1, slack_y: '1,
          feed_cut: '1, feed_skip: '0, mode: 2'b11};
    load_setup(c);
    send_item(ACT_TRAVEL, COORD_MIN, COORD_MIN, 0);
    send_item(ACT_CUT, COORD_MAX, COORD_MAX, 0);
    send_item(ACT_LIFT, 0, 0, COORD_MAX);
    send_item(ACT_TRAVEL, COORD_MAX, COORD_MIN, 0);
    cur_x = COORD_MAX;
    cur_y = COORD_MIN;
    random_run(35);
    wait_drained();

    // no slack at all, negated axes
    c = rand_setup(2'b10);
    c.slack_x = '0;
    c.slack_y = '0;
    load_setup(c);
    random_run(35);
    wait_drained();

    // random setup, linear travel; first a stretch with neither side idling
    load_setup(rand_setup(2'b01));
    idle_pct = 0;
    random_run(35);
    idle_pct = 30;
    random_run(35);
    wait_drained();

    $display("covered %0d requests over four register setups, %0d moves compared",
             n_items, moves_checked);
    if (mismatches == 0 && moves_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("timeout: moves still outstanding");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### cnc_move_sequencer_backlash.f
+incdir+rtl
rtl/cms_pkg.sv
rtl/cms_fifo.sv
rtl/cms_front.sv
rtl/cms_back.sv
rtl/cnc_move_sequencer_backlash.sv
tb/sv/cnc_move_checker.sv
tb/sv/testbench.sv
